// File: src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared definitions for the integer to ASCII converter
// Field widths, radix limits, character codes and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF   = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_TOP = 6'd35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // Digit values 0 to 9 map to '0'-'9', 10 to 35 to 'a'-'z'.
    function automatic char_t digit_to_ascii(input digit_t d);
        digit_t dc;
        char_t  c;
        begin
            dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
            if (dc < DIGIT_W'(RADIX_DEC))
            begin
                c = ASCII_ZERO + CHAR_W'(dc);
            end
            else
            begin
                c = ASCII_A + CHAR_W'(dc) - CHAR_W'(RADIX_DEC);
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ASCII string in base 2 to 36
// Converts one signed value per transfer into a stream of ASCII characters.
// ----------------------------------------------------------------------------
`default_nettype none

// One input transfer carries a signed two's complement number and a radix.
// The block answers with the characters of the number in that radix, most
// significant digit first, one character per output transfer, with tlast set
// on the final character. Digits above nine use lower-case letters. Zero
// prints as "0". In base 10 a negative number is led by '-'; in any other
// base a negative number prints as the digits of its magnitude with no sign.
// The most negative number prints correctly. A radix of 0 or 1 is treated as
// 2 and a radix above 36 as 36. The string never exceeds MAX_DIGITS
// characters including the sign; if it would, the leading digits are lost.
// Flow: the block takes one item at a time and drops s_axis_tready until
// the last character has been loaded into the output register. Each digit
// comes from a bit-serial restoring division of the magnitude by the radix.
// The sign, when there is one, is emitted next, followed by the digits,
// each read through the digit memory's registered read port; the sink can
// stall the emission by holding m_axis_tready low.
module integer_to_ascii_radix #(
    parameter int NUMBER_WIDTH = itoa_pkg::NUMBER_WIDTH_DEF,
    parameter int MAX_DIGITS   = itoa_pkg::MAX_DIGITS_DEF,
    parameter int IN_TDATA_W   =
        ((NUMBER_WIDTH + itoa_pkg::RADIX_W + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: number (NUMBER_WIDTH bits, signed), radix (6).
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0 up: character (7 bits), then one zero pad bit.
    output logic [7:0]                 m_axis_tdata,
    // Set on the final character of the string.
    output logic                       m_axis_tlast
);

    import itoa_pkg::*;

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int BW = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
    localparam int REM_W = RADIX_W + 1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_RD   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [NUMBER_WIDTH-1:0]  mag_reg, mag_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [BW-1:0]            bit_reg, bit_next;
    logic [RADIX_W-1:0]       radix_reg, radix_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     sign_reg, sign_next;
    logic                     m_valid_reg, m_valid_next;
    char_t                    m_char_reg, m_char_next;
    logic                     m_last_reg, m_last_next;
    digit_t                   rd_data_reg;

    // Digit memory: one write port for the divider, one registered read port.
    digit_t                   digit_mem [MAX_DIGITS];
    logic                     mem_we;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    // Input decode.
    logic [NUMBER_WIDTH-1:0]  in_number;
    logic [RADIX_W-1:0]       in_radix;
    logic [RADIX_W-1:0]       in_radix_sat;
    logic                     in_negative;
    logic [NUMBER_WIDTH-1:0]  in_mag;

    // Shared divide step.
    logic [REM_W-1:0]         rem_shift;
    logic                     q_bit;
    logic [REM_W-1:0]         rem_step;
    logic [NUMBER_WIDTH-1:0]  quot_step;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            digit_limit;
    logic                     out_free;

    assign in_number   = s_axis_tdata[NUMBER_WIDTH-1:0];
    assign in_radix    = s_axis_tdata[NUMBER_WIDTH +: RADIX_W];
    assign in_negative = in_number[NUMBER_WIDTH-1];
    assign in_mag      = in_negative ? (~in_number + 1'b1) : in_number;

    always_comb
    begin
        if (in_radix < RADIX_MIN)
        begin
            in_radix_sat = RADIX_MIN;
        end
        else if (in_radix > RADIX_MAX)
        begin
            in_radix_sat = RADIX_MAX;
        end
        else
        begin
            in_radix_sat = in_radix;
        end
    end

    // One restoring division step: bring in the next dividend bit, subtract
    // the radix when it fits, and shift the quotient bit into the dividend.
    assign rem_shift = {rem_reg[REM_W-2:0], mag_reg[NUMBER_WIDTH-1]};
    assign q_bit     = (rem_shift >= {1'b0, radix_reg});
    assign rem_step  = q_bit ? (rem_shift - {1'b0, radix_reg}) : rem_shift;
    assign quot_step = {mag_reg[NUMBER_WIDTH-2:0], q_bit};

    assign cnt_inc     = cnt_reg + 1'b1;
    assign digit_limit = sign_reg ? CW'(MAX_DIGITS - 1) : CW'(MAX_DIGITS);
    assign out_free    = !m_valid_reg || m_axis_tready;

    assign wr_addr = AW'(cnt_reg);
    assign rd_addr = AW'(cnt_reg - 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        radix_next   = radix_reg;
        cnt_next     = cnt_reg;
        sign_next    = sign_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        mem_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mag_next   = in_mag;
                    radix_next = in_radix_sat;
                    sign_next  = in_negative && (in_radix_sat == RADIX_DEC);
                    rem_next   = '0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next = quot_step;
                rem_next = rem_step;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BW'(NUMBER_WIDTH - 1))
                begin
                    // Remainder is the digit; quotient stays for the next one.
                    mem_we   = 1'b1;
                    cnt_next = cnt_inc;
                    rem_next = '0;
                    bit_next = '0;
                    if ((quot_step == '0) || (cnt_inc >= digit_limit))
                    begin
                        state_next = sign_reg ? ST_SIGN : ST_RD;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                // The digit memory read completes at the end of this cycle.
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_to_ascii(rd_data_reg);
                    m_last_next  = (cnt_reg == CW'(1));
                    cnt_next     = cnt_reg - 1'b1;
                    state_next   = (cnt_reg == CW'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_reg     <= '0;
            cnt_reg     <= '0;
            sign_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            mag_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            cnt_reg     <= cnt_next;
            sign_reg    <= sign_next;
            m_valid_reg <= m_valid_next;
            mag_reg     <= mag_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg  <= radix_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[wr_addr] <= digit_t'(rem_step);
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire
